// ===== rtl/mprq_pkg.sv =====
// Package with the sizes, mode codes and ring helper functions of the priority ring queue.
`timescale 1ns / 1ps

package mprq_pkg;

    localparam int NUM_PRIORITIES = 4;
    localparam int RING_DEPTH     = 16;
    localparam int NUM_CLIENTS    = 8;

    localparam int MODE_W   = 2;
    localparam int PRIO_W   = 2;
    localparam int CLIENT_W = 3;
    localparam int STAMP_W  = 32;
    localparam int FRUS_W   = 8;
    localparam int OCC_W    = 4;
    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int ADDR_W   = $clog2(NUM_PRIORITIES * RING_DEPTH);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STATUS = 2'd2;

    localparam logic [FRUS_W-1:0] FRUS_MAX = {FRUS_W{1'b1}};

    typedef logic [PTR_W-1:0] t_ptr;

    function automatic t_ptr ring_next(t_ptr pos);
        return (32'(pos) == RING_DEPTH - 1) ? '0 : pos + t_ptr'(1);
    endfunction

    function automatic logic [OCC_W-1:0] ring_count(t_ptr head, t_ptr tail);
        logic [PTR_W:0] diff;
        if (tail >= head) begin
            diff = {1'b0, tail} - {1'b0, head};
        end else begin
            diff = {1'b0, tail} + (PTR_W+1)'(RING_DEPTH) - {1'b0, head};
        end
        return OCC_W'(diff);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_addr(logic [PRIO_W-1:0] prio, t_ptr pos);
        return ADDR_W'(32'(prio) * RING_DEPTH + 32'(pos));
    endfunction

endpackage

// ===== rtl/multi_priority_ring_queue_core.sv =====
// Top level of the priority ring queue: input register with the pointer logic, client stage, output register.
//
// Usage: a word on the input channel (i_valid, o_stall) carries a mode, a priority
// level and a client id. Mode insert puts the client at the tail of the addressed
// ring, stamps it with a wrapping 32-bit arrival counter and clears its frustration
// count. Mode remove takes the head id of the ring and bumps that client's
// frustration count, which saturates at 255. Any other mode only reads status.
// Every input word yields exactly one result word on the output channel
// (o_valid, i_stall) with the ring's occupancy, empty and full flags afterwards.
// A word passes the input register, stage B and the output register. One word is
// taken per cycle while o_stall is low; the ring pointers update and the ring memory
// read is registered as a word leaves A; the client tables follow in order as it leaves B.
// Reset clears the pointers, the arrival counter, the client tables and all
// valid flags; ring entries are not cleared, as a remove only reads written slots.
// When the receiver stalls, the output word holds and the stages behind it fill
// up; o_stall rises only when every stage holds a word.
`timescale 1ns / 1ps

module multi_priority_ring_queue_core
    import mprq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [PRIO_W-1:0]   i_priority_level,
    input  logic [CLIENT_W-1:0] i_client_number,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_ok,
    output logic [CLIENT_W-1:0] o_removed_client,
    output logic [STAMP_W-1:0]  o_arrival_stamp,
    output logic [FRUS_W-1:0]   o_frustration_count,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_empty,
    output logic                o_is_full
);

    // Pipeline control.
    logic r_a_valid, r_b_valid, r_out_valid;
    logic out_free, b_free, a_free, adv_a, adv_b;

    // Stage A: registered input word.
    logic [MODE_W-1:0]   r_a_mode;
    logic [PRIO_W-1:0]   r_a_prio;
    logic [CLIENT_W-1:0] r_a_client;

    // Ring state.
    t_ptr               r_head [NUM_PRIORITIES];
    t_ptr               r_tail [NUM_PRIORITIES];
    logic [STAMP_W-1:0] r_stamp;
    logic [CLIENT_W-1:0] ring_mem [NUM_PRIORITIES*RING_DEPTH];

    // Client tables.
    logic [STAMP_W-1:0] r_arrival [NUM_CLIENTS];
    logic [FRUS_W-1:0]  r_frus    [NUM_CLIENTS];

    // Stage B registers.
    logic                r_b_ins, r_b_rem, r_b_ok, r_b_empty, r_b_full;
    logic [CLIENT_W-1:0] r_b_client, r_b_rd;
    logic [STAMP_W-1:0]  r_b_stamp;
    logic [OCC_W-1:0]    r_b_occ;

    // Output registers.
    logic                r_ok, r_empty, r_full;
    logic [CLIENT_W-1:0] r_removed;
    logic [STAMP_W-1:0]  r_out_stamp;
    logic [FRUS_W-1:0]   r_out_frus;
    logic [OCC_W-1:0]    r_occ;

    // Stage A logic.
    logic        prio_ok, a_full, a_empty, do_ins, do_rem, a_ok;
    t_ptr        a_head, a_tail, n_head, n_tail;
    logic [OCC_W-1:0] a_occ;
    logic        a_empty_after, a_full_after;

    // Stage B logic.
    logic              id_ok;
    logic [FRUS_W-1:0] frus_cur, n_frus;
    logic [STAMP_W-1:0] b_stamp;
    logic [FRUS_W-1:0]  b_frus;
    logic [CLIENT_W-1:0] b_removed;

    assign out_free = !r_out_valid || !i_stall;
    assign b_free   = !r_b_valid || out_free;
    assign a_free   = !r_a_valid || b_free;
    assign adv_a    = r_a_valid && b_free;
    assign adv_b    = r_b_valid && out_free;
    assign o_stall  = !a_free;

    always_comb begin
        prio_ok = 32'(r_a_prio) < NUM_PRIORITIES;
        a_head  = r_head[r_a_prio];
        a_tail  = r_tail[r_a_prio];
        a_full  = ring_next(a_tail) == a_head;
        a_empty = a_head == a_tail;
        do_ins  = prio_ok && (r_a_mode == MODE_INSERT) && !a_full
                  && (32'(r_a_client) < NUM_CLIENTS);
        do_rem  = prio_ok && (r_a_mode == MODE_REMOVE) && !a_empty;
        n_head  = do_rem ? ring_next(a_head) : a_head;
        n_tail  = do_ins ? ring_next(a_tail) : a_tail;
        if (!prio_ok) begin
            a_ok = 1'b0;
        end else if (r_a_mode == MODE_INSERT) begin
            a_ok = do_ins;
        end else if (r_a_mode == MODE_REMOVE) begin
            a_ok = do_rem;
        end else begin
            a_ok = 1'b1;
        end
        if (prio_ok) begin
            a_occ         = ring_count(n_head, n_tail);
            a_empty_after = n_head == n_tail;
            a_full_after  = ring_next(n_tail) == n_head;
        end else begin
            a_occ         = '0;
            a_empty_after = 1'b1;
            a_full_after  = 1'b0;
        end
    end

    always_comb begin
        id_ok     = 32'(r_b_rd) < NUM_CLIENTS;
        frus_cur  = r_frus[r_b_rd];
        n_frus    = (frus_cur == FRUS_MAX) ? frus_cur : frus_cur + FRUS_W'(1);
        b_stamp   = '0;
        b_frus    = '0;
        b_removed = '0;
        if (r_b_ins) begin
            b_stamp = r_b_stamp;
        end else if (r_b_rem) begin
            b_removed = r_b_rd;
            if (id_ok) begin
                b_stamp = r_arrival[r_b_rd];
                b_frus  = n_frus;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_stamp     <= '0;
            for (int i = 0; i < NUM_PRIORITIES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_arrival[i] <= '0;
                r_frus[i]    <= '0;
            end
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
            if (adv_a && prio_ok) begin
                r_head[r_a_prio] <= n_head;
                r_tail[r_a_prio] <= n_tail;
            end
            if (adv_a && do_ins) begin
                r_stamp <= r_stamp + STAMP_W'(1);
            end
            if (adv_b && r_b_ins) begin
                r_arrival[r_b_client] <= r_b_stamp;
                r_frus[r_b_client]    <= '0;
            end else if (adv_b && r_b_rem && id_ok) begin
                r_frus[r_b_rd] <= n_frus;
            end
        end
    end

    // Ring memory: one write port at the tail, one registered read port at the head.
    always_ff @(posedge i_clk) begin
        if (adv_a && do_ins) begin
            ring_mem[ring_addr(r_a_prio, a_tail)] <= r_a_client;
        end
        if (adv_a) begin
            r_b_rd <= ring_mem[ring_addr(r_a_prio, a_head)];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_mode   <= i_mode;
            r_a_prio   <= i_priority_level;
            r_a_client <= i_client_number;
        end
        if (adv_a) begin
            r_b_ins    <= do_ins;
            r_b_rem    <= do_rem;
            r_b_ok     <= a_ok;
            r_b_client <= r_a_client;
            r_b_stamp  <= r_stamp;
            r_b_occ    <= a_occ;
            r_b_empty  <= a_empty_after;
            r_b_full   <= a_full_after;
        end
        if (adv_b) begin
            r_ok        <= r_b_ok;
            r_removed   <= b_removed;
            r_out_stamp <= b_stamp;
            r_out_frus  <= b_frus;
            r_occ       <= r_b_occ;
            r_empty     <= r_b_empty;
            r_full      <= r_b_full;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_ok                = r_ok;
    assign o_removed_client    = r_removed;
    assign o_arrival_stamp     = r_out_stamp;
    assign o_frustration_count = r_out_frus;
    assign o_occupancy         = r_occ;
    assign o_is_empty          = r_empty;
    assign o_is_full           = r_full;

`ifndef ASSERT_OFF
    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("ring reported empty and full at once");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_removed_client == '0 && o_arrival_stamp == '0
                                && o_frustration_count == '0))
        else $error("failed operation returned data");

    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stamp != $past(r_stamp)) |-> (r_stamp == STAMP_W'($past(r_stamp) + STAMP_W'(1))))
        else $error("arrival counter moved by more than one");
`endif

endmodule
